// File: hdl/tevfm_pkg.sv
package tevfm_pkg;

   // Field widths fixed by the port list.
   localparam int FRAME_W  = 16;
   localparam int THR_W    = 4;
   localparam int RATE_W   = 16;
   localparam int PERIOD_W = 16;
   localparam int PPR_W    = 8;
   localparam int EDGES_W  = 7;
   localparam int PAIRS_W  = 6;
   localparam int SUM_W    = 22;
   localparam int FREQ_W   = 20;
   localparam int RPM_W    = 22;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int DIV_W    = 32;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_LENGTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_VOTE_THRESHOLD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RATE_HZ        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_PERIOD     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_PERIOD     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_PULSES_PER_REV = 3'd5;

   // Register values after reset.
   localparam logic [FRAME_W-1:0]  RST_FRAME_LENGTH   = 16'd2000;
   localparam logic [THR_W-1:0]    RST_VOTE_THRESHOLD = 4'd7;
   localparam logic [RATE_W-1:0]   RST_RATE_HZ        = 16'd20000;
   localparam logic [PERIOD_W-1:0] RST_MIN_PERIOD     = 16'd20;
   localparam logic [PERIOD_W-1:0] RST_MAX_PERIOD     = 16'd4000;
   localparam logic [PPR_W-1:0]    RST_PULSES_PER_REV = 8'd2;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FEW_EDGES = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_PAIRS  = 2'd2;

   // Saturation limits of the reported rates.
   localparam logic [FREQ_W-1:0] FREQ_CAP = 20'd655350;
   localparam logic [RPM_W-1:0]  RPM_CAP  = 22'd3932100;

   // Settings the edge tracker needs.
   typedef struct packed {
      logic [FRAME_W-1:0]  frame_length;
      logic [THR_W-1:0]    vote_threshold;
      logic [PERIOD_W-1:0] min_period;
      logic [PERIOD_W-1:0] max_period;
   } edge_cfg_type;

   // Running totals of the current frame, plus the end-of-frame flag.
   typedef struct packed {
      logic [EDGES_W-1:0] edges;
      logic [PAIRS_W-1:0] pairs;
      logic [SUM_W-1:0]   period_sum;
      logic               frame_end;
   } frame_sum_type;

endpackage

// File: hdl/tach_edge_vote_frequency_meter_core.sv
// Tach frequency meter. Each req beat carries one sampled tach level; samples
// form frames of frame_length positions, and the sample that ends a frame
// yields one rsp beat with the status, the edge and pair counts, and the
// rounded average frequency (0.1 Hz) and rpm. The frame-ending sample of a
// good frame starts the frame-end math: two products, then two 32-step
// divisions on a single shared restoring divider, with req_ready low until
// the result is loaded. req_ready is also low when the next sample would
// end a frame while the previous result is still waiting on rsp.
// Configuration is written through csr_we, csr_index and csr_wdata; the
// user must write it only while the block is idle; the block does not enforce it.
module tach_edge_vote_frequency_meter_core
   import tevfm_pkg::*;
#(
   parameter int WINDOW    = 8,
   parameter int MAX_EDGES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_sample_bit,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [EDGES_W-1:0]    rsp_edge_count,
   output logic [PAIRS_W-1:0]    rsp_valid_pairs,
   output logic [FREQ_W-1:0]     rsp_freq_tenths,
   output logic [RPM_W-1:0]      rsp_rpm,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [2:0] {
      ST_RUN,
      ST_MUL,
      ST_FREQ_GO,
      ST_FREQ_WAIT,
      ST_RPM_GO,
      ST_RPM_WAIT
   } state_type;

   state_type            state_ff;

   logic [FRAME_W-1:0]   frame_length_ff;
   logic [THR_W-1:0]     vote_threshold_ff;
   logic [RATE_W-1:0]    rate_hz_ff;
   logic [PERIOD_W-1:0]  min_period_ff;
   logic [PERIOD_W-1:0]  max_period_ff;
   logic [PPR_W-1:0]     ppr_ff;

   logic [SUM_W-1:0]     psum_cap_ff;
   logic [PAIRS_W-1:0]   pairs_cap_ff;
   logic [SUM_W-1:0]     base_ff;
   logic [SUM_W+PPR_W-1:0] pprod_ff;

   logic                 rsp_valid_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [EDGES_W-1:0]   rsp_edges_ff;
   logic [PAIRS_W-1:0]   rsp_pairs_ff;
   logic [FREQ_W-1:0]    rsp_freq_ff;
   logic [RPM_W-1:0]     rsp_rpm_ff;

   edge_cfg_type         edge_cfg;
   frame_sum_type        sum;
   logic                 beat;
   logic [STATUS_W-1:0]  status_now;
   logic [PPR_W-1:0]     ppr_eff;
   logic                 div_start;
   logic                 div_done;
   logic [DIV_W-1:0]     div_num;
   logic [DIV_W-1:0]     div_den;
   logic [DIV_W-1:0]     div_quo;
   logic [DIV_W-1:0]     freq_num;
   logic [DIV_W-1:0]     freq_den;
   logic [DIV_W-1:0]     rpm_num;
   logic [DIV_W-1:0]     rpm_den;
   logic [FREQ_W-1:0]    freq_sat;
   logic [RPM_W-1:0]     rpm_sat;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_length_ff   <= RST_FRAME_LENGTH;
         vote_threshold_ff <= RST_VOTE_THRESHOLD;
         rate_hz_ff        <= RST_RATE_HZ;
         min_period_ff     <= RST_MIN_PERIOD;
         max_period_ff     <= RST_MAX_PERIOD;
         ppr_ff            <= RST_PULSES_PER_REV;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_FRAME_LENGTH:   frame_length_ff   <= csr_wdata;
            REG_VOTE_THRESHOLD: vote_threshold_ff <= csr_wdata[THR_W-1:0];
            REG_RATE_HZ:        rate_hz_ff        <= csr_wdata;
            REG_MIN_PERIOD:     min_period_ff     <= csr_wdata;
            REG_MAX_PERIOD:     max_period_ff     <= csr_wdata;
            REG_PULSES_PER_REV: ppr_ff            <= csr_wdata[PPR_W-1:0];
            default: ;
         endcase
      end
   end

   assign edge_cfg.frame_length   = frame_length_ff;
   assign edge_cfg.vote_threshold = vote_threshold_ff;
   assign edge_cfg.min_period     = min_period_ff;
   assign edge_cfg.max_period     = max_period_ff;

   // A frame-ending sample waits until the output register is free.
   assign req_ready = (state_ff == ST_RUN) && !(rsp_valid_ff && sum.frame_end);
   assign beat      = req_valid && req_ready;

   tevfm_edge #(
      .WINDOW    (WINDOW),
      .MAX_EDGES (MAX_EDGES)
   ) u_edge (
      .clock  (clock),
      .reset  (reset),
      .beat   (beat),
      .sample (req_sample_bit),
      .cfg    (edge_cfg),
      .sum    (sum)
   );

   // Frame status from the running totals.
   always_comb begin
      priority if (sum.edges < EDGES_W'(2)) begin
         status_now = STATUS_FEW_EDGES;
      end else if (sum.pairs == '0 || sum.period_sum == '0) begin
         status_now = STATUS_NO_PAIRS;
      end else begin
         status_now = STATUS_OK;
      end
   end

   assign ppr_eff = (ppr_ff == '0) ? PPR_W'(1) : ppr_ff;

   // Divider operands; the added half-divisor rounds half up.
   assign freq_num = DIV_W'({base_ff, 4'b0}) + DIV_W'({base_ff, 2'b0}) + DIV_W'(psum_cap_ff);
   assign freq_den = DIV_W'({psum_cap_ff, 1'b0});
   assign rpm_num  = DIV_W'({base_ff, 7'b0}) - DIV_W'({base_ff, 3'b0}) + DIV_W'(pprod_ff);
   assign rpm_den  = DIV_W'({pprod_ff, 1'b0});

   assign div_start = (state_ff == ST_FREQ_GO) || (state_ff == ST_RPM_GO);
   assign div_num   = (state_ff == ST_RPM_GO) ? rpm_num : freq_num;
   assign div_den   = (state_ff == ST_RPM_GO) ? rpm_den : freq_den;

   tevfm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   // Clamp the quotients to the reported ranges.
   assign freq_sat = (div_quo > DIV_W'(FREQ_CAP)) ? FREQ_CAP : div_quo[FREQ_W-1:0];
   assign rpm_sat  = (div_quo > DIV_W'(RPM_CAP)) ? RPM_CAP : div_quo[RPM_W-1:0];

   // Frame-end sequencer and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_RUN: begin
               if (beat && sum.frame_end) begin
                  rsp_status_ff <= status_now;
                  rsp_edges_ff  <= sum.edges;
                  rsp_pairs_ff  <= (status_now == STATUS_FEW_EDGES) ? '0 : sum.pairs;
                  psum_cap_ff   <= sum.period_sum;
                  pairs_cap_ff  <= sum.pairs;
                  if (status_now == STATUS_OK) begin
                     state_ff <= ST_MUL;
                  end else begin
                     rsp_freq_ff  <= '0;
                     rsp_rpm_ff   <= '0;
                     rsp_valid_ff <= 1'b1;
                  end
               end
            end
            ST_MUL: begin
               base_ff  <= SUM_W'(rate_hz_ff) * SUM_W'(pairs_cap_ff);
               pprod_ff <= (SUM_W+PPR_W)'(psum_cap_ff) * (SUM_W+PPR_W)'(ppr_eff);
               state_ff <= ST_FREQ_GO;
            end
            ST_FREQ_GO: begin
               state_ff <= ST_FREQ_WAIT;
            end
            ST_FREQ_WAIT: begin
               if (div_done) begin
                  rsp_freq_ff <= freq_sat;
                  state_ff    <= ST_RPM_GO;
               end
            end
            ST_RPM_GO: begin
               state_ff <= ST_RPM_WAIT;
            end
            ST_RPM_WAIT: begin
               if (div_done) begin
                  rsp_rpm_ff   <= rpm_sat;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_RUN;
               end
            end
            default: begin
               state_ff <= ST_RUN;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_edge_count  = rsp_edges_ff;
   assign rsp_valid_pairs = rsp_pairs_ff;
   assign rsp_freq_tenths = rsp_freq_ff;
   assign rsp_rpm         = rsp_rpm_ff;

`ifndef SYNTHESIS
   // A frame result is never loaded over one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (beat && sum.frame_end) |-> !rsp_valid_ff)
      else $error("frame result loaded while previous result pending");

   // Failed frames report zero rates.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != STATUS_OK) |->
         (rsp_freq_ff == '0 && rsp_rpm_ff == '0))
      else $error("nonzero rate on a failed frame");

   // A good frame has an edge count from 2 up to MAX_EDGES and a nonzero pair count.
   a_ok_counts: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STATUS_OK) |->
         (rsp_pairs_ff != '0 && rsp_edges_ff >= EDGES_W'(2)
          && rsp_edges_ff <= EDGES_W'(MAX_EDGES)))
      else $error("inconsistent counts on a good frame");

   // Reported rates stay within their limits.
   a_caps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_freq_ff <= FREQ_CAP && rsp_rpm_ff <= RPM_CAP))
      else $error("rate above its limit");
`endif

endmodule

// File: hdl/tevfm_edge.sv
module tevfm_edge
   import tevfm_pkg::*;
#(
   parameter int WINDOW    = 8,
   parameter int MAX_EDGES = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          beat,
   input  logic          sample,
   input  edge_cfg_type  cfg,
   output frame_sum_type sum
);

   localparam int HIST_W = 2 * WINDOW;
   localparam int SKIP_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

   logic [HIST_W-1:0]   hist_ff, hist_in;
   logic [FRAME_W-1:0]  pos_ff, pos_in;
   logic [SKIP_W-1:0]   skip_ff, skip_in;
   logic [EDGES_W-1:0]  edges_ff, edges_in;
   logic [FRAME_W-1:0]  prev_ff, prev_in;
   logic [SUM_W-1:0]    psum_ff, psum_in;
   logic [PAIRS_W-1:0]  pairs_ff, pairs_in;

   logic [FRAME_W:0]    frame_len;
   logic [FRAME_W:0]    pos_next;
   logic                frame_end;
   logic [HIST_W-1:0]   hist_new;
   logic [WINDOW-1:0]   win_hi;
   logic [WINDOW-1:0]   win_lo;
   logic [THR_W-1:0]    highs;
   logic [THR_W-1:0]    lo_ones;
   logic [THR_W-1:0]    lows;
   logic                rise;
   logic                vote_ok;
   logic                cand_ok;
   logic [FRAME_W-1:0]  cand_pos;
   logic [FRAME_W-1:0]  gap;
   logic                gap_ok;

   // A zero length stands for the full 16-bit range.
   assign frame_len = (cfg.frame_length == '0) ? {1'b1, {FRAME_W{1'b0}}}
                                               : {1'b0, cfg.frame_length};
   assign pos_next  = {1'b0, pos_ff} + {{FRAME_W{1'b0}}, 1'b1};
   assign frame_end = !(pos_next < frame_len);

   // The newest sample enters at bit 0; the high half is the older window.
   assign hist_new = {hist_ff[HIST_W-2:0], sample};
   assign win_hi   = hist_new[WINDOW-1:0];
   assign win_lo   = hist_new[HIST_W-1:WINDOW];

   // Vote counts on both sides of the candidate.
   always_comb begin
      highs   = '0;
      lo_ones = '0;
      for (int k = 0; k < WINDOW; k++) begin
         highs   = highs + THR_W'(win_hi[k]);
         lo_ones = lo_ones + THR_W'(win_lo[k]);
      end
   end

   assign lows     = THR_W'(WINDOW) - lo_ones;
   assign rise     = win_hi[WINDOW-1] && !win_lo[0];
   assign vote_ok  = rise && (lows >= cfg.vote_threshold) && (highs >= cfg.vote_threshold);
   assign cand_ok  = pos_ff >= FRAME_W'(2 * WINDOW - 1);
   assign cand_pos = pos_ff - FRAME_W'(WINDOW - 1);
   assign gap      = cand_pos - prev_ff;
   assign gap_ok   = (gap >= cfg.min_period) && (gap <= cfg.max_period);

   // Next-state logic for one accepted sample.
   always_comb begin
      hist_in  = hist_ff;
      pos_in   = pos_ff;
      skip_in  = skip_ff;
      edges_in = edges_ff;
      prev_in  = prev_ff;
      psum_in  = psum_ff;
      pairs_in = pairs_ff;
      if (beat) begin
         if (frame_end) begin
            hist_in  = '0;
            pos_in   = '0;
            skip_in  = '0;
            edges_in = '0;
            prev_in  = '0;
            psum_in  = '0;
            pairs_in = '0;
         end else begin
            hist_in = hist_new;
            pos_in  = pos_next[FRAME_W-1:0];
            if (cand_ok) begin
               if (skip_ff != '0) begin
                  skip_in = skip_ff - SKIP_W'(1);
               end else if (edges_ff < EDGES_W'(MAX_EDGES) && vote_ok) begin
                  if (edges_ff != '0 && gap_ok) begin
                     psum_in  = psum_ff + SUM_W'(gap);
                     pairs_in = pairs_ff + PAIRS_W'(1);
                  end
                  prev_in  = cand_pos;
                  edges_in = edges_ff + EDGES_W'(1);
                  skip_in  = SKIP_W'(WINDOW - 1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff  <= '0;
         pos_ff   <= '0;
         skip_ff  <= '0;
         edges_ff <= '0;
         prev_ff  <= '0;
         psum_ff  <= '0;
         pairs_ff <= '0;
      end else begin
         hist_ff  <= hist_in;
         pos_ff   <= pos_in;
         skip_ff  <= skip_in;
         edges_ff <= edges_in;
         prev_ff  <= prev_in;
         psum_ff  <= psum_in;
         pairs_ff <= pairs_in;
      end
   end

   assign sum.edges      = edges_ff;
   assign sum.pairs      = pairs_ff;
   assign sum.period_sum = psum_ff;
   assign sum.frame_end  = frame_end;

endmodule

// File: hdl/tevfm_div.sv
module tevfm_div
   import tevfm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] num,
   input  logic [DIV_W-1:0] den,
   output logic             done,
   output logic [DIV_W-1:0] quo
);

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DIV_W-1:0] rem_ff;
   logic [DIV_W-1:0] den_ff;
   logic [DIV_W-1:0] dq_ff;

   logic [DIV_W:0]   trial;
   logic             fits;
   logic [DIV_W:0]   diff;

   // One restoring step: bring down the next dividend bit and try the subtract.
   assign trial = {rem_ff, dq_ff[DIV_W-1]};
   assign fits  = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && !start && (cnt_ff == CNT_W'(1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DIV_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // Datapath registers need no reset.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         den_ff <= den;
         dq_ff  <= num;
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         dq_ff  <= {dq_ff[DIV_W-2:0], fits};
      end
   end

   assign done = done_ff;
   assign quo  = dq_ff;

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

import tevfm_pkg::*;

localparam int VOTE_WINDOW = 8;
localparam int EDGE_LIMIT  = 64;

// Indexes that hold no register; writes to them must change nothing.
localparam logic [CSR_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
localparam logic [CSR_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

// One frame report as it appears on the rsp channel.
typedef struct packed {
   logic [STATUS_W-1:0] status;
   logic [EDGES_W-1:0]  edge_count;
   logic [PAIRS_W-1:0]  valid_pairs;
   logic [FREQ_W-1:0]   freq_tenths;
   logic [RPM_W-1:0]    rpm;
} meter_result_type;

// Tracks the meter's registers and frame state, and holds the reports still owed.
class tach_scoreboard;
   logic [FRAME_W-1:0]  frame_length;
   logic [THR_W-1:0]    vote_threshold;
   logic [RATE_W-1:0]   rate_hz;
   logic [PERIOD_W-1:0] min_period;
   logic [PERIOD_W-1:0] max_period;
   logic [PPR_W-1:0]    pulses_per_rev;

   logic [2*VOTE_WINDOW-1:0] history;
   logic [FRAME_W-1:0]       position;
   int unsigned              skip_left;
   logic [EDGES_W-1:0]       edges;
   logic [FRAME_W-1:0]       last_edge;
   logic [SUM_W-1:0]         period_sum;
   logic [PAIRS_W-1:0]       pairs;

   meter_result_type expected_reports[$];
   int unsigned frames_closed;
   int          errors;

   function new();
      frame_length   = RST_FRAME_LENGTH;
      vote_threshold = RST_VOTE_THRESHOLD;
      rate_hz        = RST_RATE_HZ;
      min_period     = RST_MIN_PERIOD;
      max_period     = RST_MAX_PERIOD;
      pulses_per_rev = RST_PULSES_PER_REV;
      frames_closed  = 0;
      errors         = 0;
      clear_frame();
   endfunction

   function void clear_frame();
      history    = '0;
      position   = '0;
      skip_left  = 0;
      edges      = '0;
      last_edge  = '0;
      period_sum = '0;
      pairs      = '0;
   endfunction

   function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      case (idx)
         REG_FRAME_LENGTH:   frame_length   = value[FRAME_W-1:0];
         REG_VOTE_THRESHOLD: vote_threshold = value[THR_W-1:0];
         REG_RATE_HZ:        rate_hz        = value[RATE_W-1:0];
         REG_MIN_PERIOD:     min_period     = value[PERIOD_W-1:0];
         REG_MAX_PERIOD:     max_period     = value[PERIOD_W-1:0];
         REG_PULSES_PER_REV: pulses_per_rev = value[PPR_W-1:0];
         default: ;
      endcase
   endfunction

   // Division rounded to nearest, a half rounding up.
   function longint unsigned div_nearest(longint unsigned num, longint unsigned den);
      return (2 * num + den) / (2 * den);
   endfunction

   // Advances the frame by one accepted sample beat; a frame's last sample queues a report.
   function void note_sample(bit level);
      int unsigned              span;
      int unsigned              p;
      int unsigned              cand;
      int unsigned              highs;
      int unsigned              lows;
      int unsigned              gap;
      logic [VOTE_WINDOW-1:0]   newer;
      logic [VOTE_WINDOW-1:0]   older;
      longint unsigned          base;
      longint unsigned          ppr;
      longint unsigned          freq;
      longint unsigned          rev;
      meter_result_type         rep;

      span    = (frame_length == 0) ? 65536 : frame_length;
      p       = position;
      history = {history[2*VOTE_WINDOW-2:0], level};

      if (p + 1 < span) begin
         // The candidate at p - WINDOW + 1 is judged once its whole high window is in.
         if (p >= 2 * VOTE_WINDOW - 1) begin
            if (skip_left > 0) begin
               skip_left--;
            end else if (edges < EDGE_LIMIT) begin
               cand  = p - VOTE_WINDOW + 1;
               newer = history[VOTE_WINDOW-1:0];
               older = history[2*VOTE_WINDOW-1:VOTE_WINDOW];
               highs = $countones(newer);
               lows  = VOTE_WINDOW - $countones(older);
               if (newer[VOTE_WINDOW-1] && !older[0] &&
                   lows >= vote_threshold && highs >= vote_threshold) begin
                  if (edges > 0) begin
                     gap = (cand - last_edge) & 32'hFFFF;
                     if (gap >= min_period && gap <= max_period) begin
                        period_sum = SUM_W'(period_sum + gap);
                        pairs      = PAIRS_W'(pairs + 1);
                     end
                  end
                  last_edge = FRAME_W'(cand);
                  edges     = EDGES_W'(edges + 1);
                  skip_left = VOTE_WINDOW - 1;
               end
            end
         end
         position = FRAME_W'(p + 1);
         return;
      end

      // Frame end: build the report, then start a fresh frame.
      freq = 0;
      rev  = 0;
      rep.edge_count  = edges;
      rep.valid_pairs = pairs;
      if (edges < 2) begin
         rep.status      = STATUS_FEW_EDGES;
         rep.valid_pairs = '0;
      end else if (pairs == 0 || period_sum == 0) begin
         rep.status = STATUS_NO_PAIRS;
      end else begin
         rep.status = STATUS_OK;
         ppr  = (pulses_per_rev == 0) ? 1 : pulses_per_rev;
         base = rate_hz;
         base = base * pairs;
         freq = div_nearest(base * 10, period_sum);
         rev  = div_nearest(base * 60, ppr * period_sum);
         if (freq > FREQ_CAP) freq = FREQ_CAP;
         if (rev > RPM_CAP) rev = RPM_CAP;
      end
      rep.freq_tenths = FREQ_W'(freq);
      rep.rpm         = RPM_W'(rev);
      expected_reports.push_back(rep);
      frames_closed++;
      clear_frame();
   endfunction

   // Compares one rsp beat with the oldest report still owed.
   function void check_result(meter_result_type got);
      meter_result_type want;
      if (expected_reports.size() == 0) begin
         $error("rsp beat with no report expected: status %0d edges %0d",
                got.status, got.edge_count);
         errors++;
         return;
      end
      want = expected_reports.pop_front();
      if (got.status !== want.status) begin
         $error("status: expected %0d, got %0d", want.status, got.status);
         errors++;
      end
      if (got.edge_count !== want.edge_count) begin
         $error("edge_count: expected %0d, got %0d", want.edge_count, got.edge_count);
         errors++;
      end
      if (got.valid_pairs !== want.valid_pairs) begin
         $error("valid_pairs: expected %0d, got %0d", want.valid_pairs, got.valid_pairs);
         errors++;
      end
      if (got.freq_tenths !== want.freq_tenths) begin
         $error("freq_tenths: expected %0d, got %0d", want.freq_tenths, got.freq_tenths);
         errors++;
      end
      if (got.rpm !== want.rpm) begin
         $error("rpm: expected %0d, got %0d", want.rpm, got.rpm);
         errors++;
      end
   endfunction

   function int pending();
      return expected_reports.size();
   endfunction
endclass

module testbench;

   localparam int RANDOM_ITEMS    = 280;
   localparam int RANDOM_FRAMES   = 6;
   localparam int DRAIN_CYCLES    = 100;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int QUIET_LIMIT     = 3000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_sample_bit = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [STATUS_W-1:0]   rsp_status;
   logic [EDGES_W-1:0]    rsp_edge_count;
   logic [PAIRS_W-1:0]    rsp_valid_pairs;
   logic [FREQ_W-1:0]     rsp_freq_tenths;
   logic [RPM_W-1:0]      rsp_rpm;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   bit idle_en = 1'b1;
   bit hold_req = 1'b0;
   bit hold_done = 1'b0;
   int hold_left = 0;
   int quiet_cycles = 0;

   tach_scoreboard sb = new();

   tach_edge_vote_frequency_meter_core #(
      .WINDOW(VOTE_WINDOW),
      .MAX_EDGES(EDGE_LIMIT)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_sample_bit(req_sample_bit),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_edge_count(rsp_edge_count),
      .rsp_valid_pairs(rsp_valid_pairs),
      .rsp_freq_tenths(rsp_freq_tenths),
      .rsp_rpm(rsp_rpm),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Both channels are observed at the edge, before any flop in the block updates.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.note_sample(req_sample_bit);
         end
         if (rsp_valid && rsp_ready) begin
            sb.check_result('{rsp_status, rsp_edge_count, rsp_valid_pairs,
                              rsp_freq_tenths, rsp_rpm});
         end
      end
   end

   // Report receiver: random stalls, plus one long hold-off when asked for.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else if (hold_req && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= RSP_HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !(idle_en && $urandom_range(0, 99) < 7);
      end
   end

   // Ends the run if no beat moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offers one sample beat, possibly after a random gap, and waits until it is taken.
   task automatic send_sample(input bit level);
      while (idle_en && $urandom_range(0, 99) < 7) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_sample_bit <= level;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_level(input bit level, input int count);
      for (int k = 0; k < count; k++) send_sample(level);
   endtask

   task automatic send_random_bits(input int count);
      for (int k = 0; k < count; k++) send_sample(1'($urandom_range(0, 1)));
   endtask

   // Tach-like square wave starting low; run lengths drawn from a range, with bit noise.
   task automatic send_wave(input int count, input int run_min, input int run_max,
                            input int noise_pct);
      bit level;
      int run_left;
      level    = 1'b0;
      run_left = $urandom_range(run_min, run_max);
      for (int k = 0; k < count; k++) begin
         if (run_left == 0) begin
            level    = !level;
            run_left = $urandom_range(run_min, run_max);
         end
         run_left--;
         send_sample(level ^ ($urandom_range(0, 99) < noise_pct));
      end
   endtask

   // Stops offering samples, waits for every owed report, then lets the block go quiet.
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      sb.set_register(idx, CSR_DATA_W'(value));
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic configure(input int len, input int thr, input int rate,
                            input int minp, input int maxp, input int ppr);
      settle();
      write_reg(REG_FRAME_LENGTH, len);
      write_reg(REG_VOTE_THRESHOLD, thr);
      write_reg(REG_RATE_HZ, rate);
      write_reg(REG_MIN_PERIOD, minp);
      write_reg(REG_MAX_PERIOD, maxp);
      write_reg(REG_PULSES_PER_REV, ppr);
   endtask

   initial begin : stimulus
      int random_items;
      int frames_before;
      int phase;
      int len;
      int thr;
      int minp;
      int maxp;
      int run_min;
      int count;
      int pick;

      random_items = 0;
      phase        = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset values of every register but the frame length.
      settle();
      write_reg(REG_FRAME_LENGTH, 40);
      send_wave(40, 10, 10, 0);
      send_level(1'b0, 40);
      send_level(1'b1, 40);
      send_level(1'b0, 20);
      send_level(1'b1, 20);

      // Inverted period bounds, then both threshold extremes.
      configure(40, 7, 20000, 50, 10, 2);
      send_wave(40, 10, 10, 0);
      configure(40, 0, 1000, 1, 65535, 1);
      send_random_bits(40);
      configure(40, 8, 1000, 1, 65535, 3);
      send_wave(40, 9, 9, 0);

      // A threshold above the window size accepts no edge.
      configure(40, 15, 1000, 1, 65535, 3);
      send_wave(40, 10, 10, 0);

      // Shortest gaps at the top rate; zero and largest pulses per revolution.
      configure(40, 4, 65535, 1, 65535, 0);
      send_wave(40, 4, 4, 0);
      configure(40, 4, 1, 8, 8, 255);
      send_wave(40, 4, 4, 0);

      // Writes to indexes with no register behind them.
      settle();
      write_reg(REG_UNUSED_LO, 16'hFFFF);
      write_reg(REG_UNUSED_HI, 16'hFFFF);

      // Smallest frame that holds a candidate, then frames too short for any candidate.
      configure(17, 7, 20000, 1, 65535, 1);
      send_wave(51, 8, 8, 0);
      configure(1, 7, 20000, 1, 65535, 1);
      send_random_bits(6);
      configure(5, 7, 20000, 1, 65535, 1);
      send_random_bits(10);

      // A zero length keeps the frame open; lowering the length below the
      // position mid-frame makes the next sample end it.
      configure(0, 7, 20000, 20, 4000, 2);
      send_wave(100, 10, 10, 0);
      configure(30, 7, 20000, 20, 4000, 2);
      send_sample(1'b0);

      // Random settings and waveforms; frames carry over from one setting to the next.
      frames_before = sb.frames_closed;
      while (random_items < RANDOM_ITEMS || sb.frames_closed - frames_before < RANDOM_FRAMES)
      begin
         phase++;
         pick = $urandom_range(0, 99);
         if (phase == 3)      len = 20;
         else if (pick < 85)  len = $urandom_range(17, 40);
         else if (pick < 95)  len = $urandom_range(1, 16);
         else                 len = $urandom_range(41, 300);
         thr  = ($urandom_range(0, 99) < 75) ? $urandom_range(5, 8) : $urandom_range(0, 15);
         minp = ($urandom_range(0, 99) < 70) ? $urandom_range(1, 20) : $urandom_range(1, 65535);
         maxp = ($urandom_range(0, 99) < 70) ? $urandom_range(20, 60) : $urandom_range(1, 65535);
         configure(len, thr, $urandom_range(1, 65535), minp, maxp, $urandom_range(0, 255));

         // Quiet stretch with no idling; one long receiver hold-off while samples keep coming.
         idle_en <= (phase != 2);
         if (phase == 3) hold_req <= 1'b1;

         count = $urandom_range(60, 110);
         if ($urandom_range(0, 99) < 80) begin
            run_min = $urandom_range(4, 12);
            send_wave(count, run_min, run_min + $urandom_range(0, 20), $urandom_range(0, 3));
         end else begin
            send_random_bits(count);
         end
         random_items += count;
      end

      settle();
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// File: files.f
hdl/tevfm_pkg.sv
hdl/tevfm_edge.sv
hdl/tevfm_div.sv
hdl/tach_edge_vote_frequency_meter_core.sv
sim/testbench.sv
